>>> rtl/pkf_pkg.sv
// Package for the per-pixel scalar Kalman filter: sizes, codes, types.
package pkf_pkg;

	localparam int IMAGE_COLUMNS = 256;
	localparam int IMAGE_ROWS    = 64;
	localparam int PIXEL_COUNT   = IMAGE_COLUMNS * IMAGE_ROWS;
	localparam int PIX_AW        = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	localparam int PX_W   = 14;
	localparam int DIST_W = 16;
	localparam int EST_W  = 24;
	localparam int GAIN_W = 16;
	localparam int COV_W  = 24;
	localparam int NOISE_W = 12;
	localparam int ENTRY_W = EST_W + GAIN_W + COV_W;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_DIST = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(3);

	localparam logic [DIST_W-1:0]  THRESHOLD_RST  = DIST_W'(16000);
	localparam logic [DIST_W-1:0]  RESET_DIST_RST = DIST_W'(40);
	localparam logic [NOISE_W-1:0] PROC_NOISE_RST = NOISE_W'(50);
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = NOISE_W'(200);
	localparam logic [COV_W-1:0]   COV_RST        = COV_W'(24'h014000);

	// quotient bits produced by the gain divider
	localparam int DIV_STEPS = GAIN_W + 1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_READ,
		ST_PRED,
		ST_MUL1,
		ST_EST,
		ST_DIV,
		ST_MUL2,
		ST_WB,
		ST_BYP
	} pkf_state_t;

	typedef struct packed {
		logic in_ready;
		logic ram_we;
		logic clear_wr;
		logic load_filt;
		logic load_byp;
		logic mul_cov;
	} pkf_ctrl_t;

endpackage

>>> rtl/pkf_if.sv
// Handshake interfaces for pixel input, filtered output and register writes.
interface pkf_in_if;
	logic                         valid;
	logic                         ready;
	logic [pkf_pkg::PX_W-1:0]     pixel_index;
	logic [pkf_pkg::DIST_W-1:0]   raw_distance;

	modport source (output valid, pixel_index, raw_distance, input ready);
	modport sink (input valid, pixel_index, raw_distance, output ready);
endinterface

interface pkf_out_if;
	logic                         valid;
	logic                         ready;
	logic [pkf_pkg::DIST_W-1:0]   filtered_distance;
	logic                         was_reset;
	logic                         was_bypassed;

	modport source (output valid, filtered_distance, was_reset, was_bypassed, input ready);
	modport sink (input valid, filtered_distance, was_reset, was_bypassed, output ready);
endinterface

interface pkf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pkf_pkg::CFG_IDX_W-1:0]    index;
	logic [pkf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pkf_ram.sv
// Generic simple dual-port RAM with registered read.
module pkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/per_pixel_scalar_kalman_filter.sv
// Top level: per-pixel scalar Kalman filter with sequencer, shared multiplier and gain divider.
//
//  channel  | dir | fields                                        | accepted when
//  pix_in   | in  | pixel_index[14], raw_distance[16]             | valid && ready
//  pix_out  | out | filtered_distance[16], was_reset, was_bypassed | valid && ready
//  cfg      | in  | index[4], data[16]                            | valid && ready (ready = 1)
//
// A filtered item passes through the wrap, read, predict, multiply, estimate, divide,
// multiply and write-back states; the 17-step restoring gain divider is the longest part.
// A bypassed item loads its result from the bypass state. The block is ready again
// the cycle after the result is loaded. After reset a clearing pass writes every
// pixel entry before pix_in.ready first rises; register writes are taken during it.
// The result sits in an output register; the next item may be accepted while it waits.
module per_pixel_scalar_kalman_filter (
	input  logic       clk,
	input  logic       arst_n,
	pkf_in_if.sink     pix_in,
	pkf_out_if.source  pix_out,
	pkf_cfg_if.sink    cfg
);
	import pkf_pkg::*;

	pkf_state_t state_q, state_d;
	pkf_ctrl_t  ctrl;

	logic [DIST_W-1:0]  thr_q, rdist_q;
	logic [NOISE_W-1:0] qn_q, rn_q;

	logic [PIX_AW-1:0] clr_q;
	logic [PX_W-1:0]   px_q;
	logic [DIST_W-1:0] raw_q;

	logic [EST_W-1:0]  x_q;
	logic [GAIN_W-1:0] kold_q, k_q;
	logic [COV_W-1:0]  pp_q;
	logic              neg_q;
	logic [EST_W:0]    mag_q;
	logic [40:0]       prod_q;
	logic [EST_W:0]    den_q;
	logic [EST_W:0]    rem_q;
	logic [DIV_STEPS-1:0] nb_q, quo_q;
	logic [4:0]        cnt_q;

	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_rst_q, out_byp_q;

	logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
	logic [PIX_AW-1:0]  ram_waddr, ram_raddr;

	logic              out_free, px_over, clr_last;
	logic [EST_W:0]    mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic [40:0]       mul_p;
	logic [EST_W:0]    cov_sum;
	logic [EST_W+1:0]  diff;
	logic [EST_W+2:0]  xn;
	logic [EST_W:0]    trial;
	logic [EST_W:0]    trial_sub;
	logic              trial_ge;
	logic [GAIN_W-1:0] k_new;
	logic [COV_W-1:0]  cov_new;
	logic [DIST_W-1:0] est16, delta;
	logic              do_reset;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RST;
			rdist_q <= RESET_DIST_RST;
			qn_q    <= PROC_NOISE_RST;
			rn_q    <= MEAS_NOISE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_THRESHOLD:  thr_q   <= cfg.data;
				CFG_RESET_DIST: rdist_q <= cfg.data;
				CFG_PROC_NOISE: qn_q    <= cfg.data[NOISE_W-1:0];
				CFG_MEAS_NOISE: rn_q    <= cfg.data[NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || pix_out.ready;
	assign px_over  = 32'(px_q) >= PIXEL_COUNT;
	assign clr_last = clr_q == PIX_AW'(PIXEL_COUNT - 1);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (pix_in.valid) begin
					state_d = (pix_in.raw_distance >= thr_q) ? ST_BYP : ST_WRAP;
				end
			end
			ST_WRAP: if (!px_over) state_d = ST_READ;
			ST_READ: state_d = ST_PRED;
			ST_PRED: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_EST;
			ST_EST:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == 5'd0) state_d = ST_MUL2;
			ST_MUL2: state_d = ST_WB;
			ST_WB:   if (out_free) state_d = ST_IDLE;
			ST_BYP:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.ram_we   = 1'b1;
				ctrl.clear_wr = 1'b1;
			end
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_MUL2: ctrl.mul_cov = 1'b1;
			ST_WB: begin
				ctrl.ram_we    = out_free;
				ctrl.load_filt = out_free;
			end
			ST_BYP: ctrl.load_byp = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PIX_AW'(1);
			end
		end
	end

	assign pix_in.ready = ctrl.in_ready;

	// shared multiplier
	assign mul_a = ctrl.mul_cov ? {1'b0, pp_q} : mag_q;
	assign mul_b = ctrl.mul_cov ? k_new : kold_q;
	assign mul_p = 41'(mul_a) * 41'(mul_b);

	assign cov_sum = {1'b0, ram_rdata[COV_W-1:0]} + {1'b0, qn_q, 12'd0};
	assign diff    = {2'b00, raw_q, 8'd0} - {2'b00, ram_rdata[ENTRY_W-1 -: EST_W]};
	assign xn      = neg_q ? ({3'b000, x_q} - {2'b00, prod_q[40:16]})
	                       : ({3'b000, x_q} + {2'b00, prod_q[40:16]});

	assign trial     = {rem_q[EST_W-1:0], nb_q[DIV_STEPS-1]};
	assign trial_ge  = {rem_q[EST_W], trial} >= {1'b0, den_q};
	assign trial_sub = trial - den_q;

	assign k_new   = (den_q == '0) ? '0
	               : (quo_q[DIV_STEPS-1] ? '1 : quo_q[GAIN_W-1:0]);
	assign cov_new = pp_q - prod_q[39:16];
	assign est16   = x_q[EST_W-1:8];
	assign delta   = (est16 > raw_q) ? (est16 - raw_q) : (raw_q - est16);
	assign do_reset = delta >= rdist_q;

	always_ff @(posedge clk) begin
		if (ctrl.in_ready && pix_in.valid) begin
			px_q  <= pix_in.pixel_index;
			raw_q <= pix_in.raw_distance;
		end
		unique case (state_q)
			ST_WRAP: if (px_over) px_q <= px_q - PX_W'(PIXEL_COUNT);
			ST_PRED: begin
				x_q    <= ram_rdata[ENTRY_W-1 -: EST_W];
				kold_q <= ram_rdata[COV_W +: GAIN_W];
				pp_q   <= cov_sum[EST_W] ? '1 : cov_sum[COV_W-1:0];
				neg_q  <= diff[EST_W+1];
				mag_q  <= diff[EST_W+1] ? (~diff[EST_W:0] + 1'b1) : diff[EST_W:0];
			end
			ST_MUL1: prod_q <= mul_p;
			ST_EST: begin
				if (xn[EST_W+2]) begin
					x_q <= '0;
				end else if (xn[EST_W+1:EST_W] != 2'b00) begin
					x_q <= '1;
				end else begin
					x_q <= xn[EST_W-1:0];
				end
				den_q <= {1'b0, pp_q} + {1'b0, rn_q, 12'd0};
				rem_q <= {2'b00, pp_q[COV_W-1:1]};
				nb_q  <= {pp_q[0], {GAIN_W{1'b0}}};
				quo_q <= '0;
				cnt_q <= 5'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				rem_q <= trial_ge ? trial_sub : trial;
				quo_q <= {quo_q[DIV_STEPS-2:0], trial_ge};
				nb_q  <= {nb_q[DIV_STEPS-2:0], 1'b0};
				cnt_q <= cnt_q - 5'd1;
			end
			ST_MUL2: begin
				k_q    <= k_new;
				prod_q <= mul_p;
			end
			default: ;
		endcase
	end

	// entry: estimate, gain, covariance
	assign ram_waddr = ctrl.clear_wr ? clr_q : PIX_AW'(px_q);
	assign ram_raddr = PIX_AW'(px_q);
	assign ram_wdata = ctrl.clear_wr ? {{EST_W{1'b0}}, {GAIN_W{1'b0}}, COV_RST}
	                 : {(do_reset ? {raw_q, 8'd0} : x_q), k_q, cov_new};

	pkf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PIXEL_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_filt || ctrl.load_byp) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_filt) begin
			out_dist_q <= do_reset ? raw_q : est16;
			out_rst_q  <= do_reset;
			out_byp_q  <= 1'b0;
		end else if (ctrl.load_byp) begin
			out_dist_q <= raw_q;
			out_rst_q  <= 1'b0;
			out_byp_q  <= 1'b1;
		end
	end

	assign pix_out.valid             = out_valid_q;
	assign pix_out.filtered_distance = out_dist_q;
	assign pix_out.was_reset         = out_rst_q;
	assign pix_out.was_bypassed      = out_byp_q;

endmodule
